// ===== sv/gww_pkg.sv =====
// Shared types and constants for the greedy word wrap block.
// Used by gww_ctrl, gww_datapath and greedy_word_wrap; depends on nothing.
package gww_pkg;

    localparam int MAX_WIDTH   = 61;
    localparam int STORE_DEPTH = MAX_WIDTH + 1;
    localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    localparam logic [LEN_W-1:0] WIDTH_MAX   = LEN_W'(MAX_WIDTH);
    localparam logic [LEN_W-1:0] WIDTH_RESET = LEN_W'(40);

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Emission stages, in the order in which one item emits them.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NL1,
        ST_WORD,
        ST_CHAR,
        ST_SPACE,
        ST_TAIL,
        ST_STATUS
    } state_t;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_NL,
        SEL_WORD,
        SEL_CHAR,
        SEL_SPACE
    } sel_t;

    // What one accepted item emits.
    typedef struct packed {
        logic       nl_first;   // leading newline
        logic       word;       // buffered word bytes
        logic       in_char;    // the input byte itself
        logic       space;      // separating space
        logic [1:0] tail_nl;    // trailing newlines
    } plan_t;

    typedef struct packed {
        logic accept;
        logic load;
        sel_t sel;
        logic last;
        logic idx_adv;
    } ctrl_cmd_t;

    typedef struct packed {
        plan_t plan;
        logic  word_last;
        logic  can_load;
    } dp_status_t;

    // Next emission stage after stage 'from'; ST_IDLE when nothing is left.
    function automatic state_t stage_after(input state_t from, input plan_t p);
        state_t nxt;
        nxt = ST_IDLE;
        if (from == ST_IDLE && p.nl_first) begin
            nxt = ST_NL1;
        end else if ((from inside {ST_IDLE, ST_NL1}) && p.word) begin
            nxt = ST_WORD;
        end else if ((from inside {ST_IDLE, ST_NL1, ST_WORD}) && p.in_char) begin
            nxt = ST_CHAR;
        end else if ((from inside {ST_IDLE, ST_NL1, ST_WORD, ST_CHAR}) && p.space) begin
            nxt = ST_SPACE;
        end else if ((from inside {ST_IDLE, ST_NL1, ST_WORD, ST_CHAR, ST_SPACE})
                     && (p.tail_nl != 2'd0)) begin
            nxt = ST_TAIL;
        end
        return nxt;
    endfunction

endpackage

// ===== sv/gww_ctrl.sv =====
// Controller state machine: steps through the emission stages of one item.
// Depends on gww_pkg; drives commands into gww_datapath.
module gww_ctrl
    import gww_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t     state_reg, state_next;
    plan_t      plan_reg, plan_next;
    logic [1:0] tail_left_reg, tail_left_next;
    state_t     after_cur;
    logic       emitting;

    assign emitting  = (state_reg != ST_IDLE);
    assign after_cur = stage_after(state_reg, plan_reg);

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        plan_next      = plan_reg;
        tail_left_next = tail_left_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    plan_next      = status.plan;
                    tail_left_next = status.plan.tail_nl;
                    state_next     = stage_after(ST_IDLE, status.plan);
                    if (state_next == ST_IDLE) begin
                        state_next = ST_STATUS;
                    end
                end
            end
            ST_WORD:
            begin
                if (status.can_load && status.word_last) begin
                    state_next = after_cur;
                end
            end
            ST_TAIL:
            begin
                if (status.can_load) begin
                    tail_left_next = tail_left_reg - 2'd1;
                    if (tail_left_reg == 2'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_STATUS:
            begin
                if (status.can_load) begin
                    state_next = ST_IDLE;
                end
            end
            ST_NL1, ST_CHAR, ST_SPACE:
            begin
                if (status.can_load) begin
                    state_next = after_cur;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        cmd.sel      = SEL_NONE;
        in_stall     = emitting;
        cmd.accept   = (state_reg == ST_IDLE) && in_valid;
        cmd.load     = emitting && status.can_load;
        case (state_reg)
            ST_NL1:
            begin
                cmd.sel  = SEL_NL;
                cmd.last = (after_cur == ST_IDLE);
            end
            ST_WORD:
            begin
                cmd.sel     = SEL_WORD;
                cmd.last    = status.word_last && (after_cur == ST_IDLE);
                cmd.idx_adv = status.can_load && !status.word_last;
            end
            ST_CHAR:
            begin
                cmd.sel  = SEL_CHAR;
                cmd.last = (after_cur == ST_IDLE);
            end
            ST_SPACE:
            begin
                cmd.sel  = SEL_SPACE;
                cmd.last = (after_cur == ST_IDLE);
            end
            ST_TAIL:
            begin
                cmd.sel  = SEL_NL;
                cmd.last = (tail_left_reg == 2'd1);
            end
            ST_STATUS:
            begin
                cmd.sel  = SEL_NONE;
                cmd.last = 1'b1;
            end
            default:
            begin
                cmd.sel = SEL_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            plan_reg      <= '0;
            tail_left_reg <= 2'd0;
        end else begin
            state_reg     <= state_next;
            plan_reg      <= plan_next;
            tail_left_reg <= tail_left_next;
        end
    end

endmodule

// ===== sv/gww_datapath.sv =====
// Datapath: text state, word store, emission plan and output register.
// Depends on gww_pkg; commanded by gww_ctrl.
module gww_datapath
    import gww_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [LEN_W-1:0] cfg_data,
    input  logic [7:0]       in_byte,
    input  logic             end_of_text,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       status,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             last_of_run,
    output logic             too_long_seen
);

    // Configuration and text state
    logic [LEN_W-1:0] line_width_reg;
    logic [LEN_W-1:0] word_len_reg, word_len_next;
    logic             streaming_reg, streaming_next;
    logic [LEN_W-1:0] line_used_reg, line_used_next;
    logic             break_reg, break_next;
    logic             last_nl_reg, last_nl_next;
    logic             lfo_reg, lfo_next;
    logic             err_reg, err_next;
    logic             flushed_reg, flushed_next;

    // Per-item holding registers and word store
    logic [LEN_W-1:0] emit_len_reg;
    logic [7:0]       char_hold_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data_reg;
    logic [7:0]       word_store [STORE_DEPTH];
    logic             store_we;

    // Output register
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             byte_valid_reg;
    logic             last_reg;
    logic             err_out_reg;
    logic [7:0]       out_byte_mux;

    // Flush arithmetic
    logic [LEN_W-1:0] w;
    logic [LEN_W-1:0] w_plus1;
    logic [LEN_W:0]   sum;
    logic             over;
    logic [LEN_W-1:0] lu_word;
    logic             f_space;
    logic [LEN_W-1:0] lu_flush;
    logic             is_ws;
    logic             is_nl;
    logic             para;
    plan_t            plan;

    assign w = (line_width_reg == '0) ? LEN_W'(1) :
               ((line_width_reg > WIDTH_MAX) ? WIDTH_MAX : line_width_reg);
    assign w_plus1  = w + LEN_W'(1);
    assign sum      = {1'b0, line_used_reg} + {1'b0, word_len_reg};
    assign over     = streaming_reg || (word_len_reg > w);
    assign lu_word  = over ? w_plus1 :
                      ((sum <= {1'b0, w}) ? sum[LEN_W-1:0] : word_len_reg);
    assign f_space  = !over && (word_len_reg != '0) && (lu_word < w);
    assign lu_flush = lu_word + {{(LEN_W-1){1'b0}}, f_space};
    assign is_ws    = in_byte inside {[8'd9:8'd13], 8'd32};
    assign is_nl    = (in_byte == CH_NL);
    assign para     = is_nl && last_nl_reg;

    // Plan and next text state for the item on the input
    always_comb
    begin
        plan           = '0;
        store_we       = 1'b0;
        word_len_next  = word_len_reg;
        streaming_next = streaming_reg;
        line_used_next = line_used_reg;
        break_next     = break_reg;
        last_nl_next   = last_nl_reg;
        lfo_next       = lfo_reg;
        err_next       = err_reg;
        flushed_next   = flushed_reg;
        if (end_of_text) begin
            if (flushed_reg || (word_len_reg != '0) || streaming_reg) begin
                plan.nl_first = over ? !streaming_reg : (sum > {1'b0, w});
                plan.word     = !streaming_reg && (word_len_reg != '0);
                plan.space    = f_space;
                plan.tail_nl  = over ? 2'd0 : 2'd1;
                err_next      = err_reg || over;
            end
            // Back to the start of a new text
            word_len_next  = '0;
            streaming_next = 1'b0;
            line_used_next = '0;
            break_next     = 1'b0;
            last_nl_next   = 1'b0;
            lfo_next       = 1'b0;
            flushed_next   = 1'b0;
        end else if (is_ws) begin
            plan.nl_first  = over ? !streaming_reg : (sum > {1'b0, w});
            plan.word      = !streaming_reg && (word_len_reg != '0);
            plan.space     = f_space;
            plan.tail_nl   = (para && !break_reg) ? 2'd2 : 2'd0;
            err_next       = err_reg || over;
            lfo_next       = over;
            word_len_next  = '0;
            streaming_next = 1'b0;
            flushed_next   = 1'b1;
            line_used_next = para ? '0 : lu_flush;
            break_next     = break_reg || para;
            last_nl_next   = last_nl_reg || is_nl;
        end else begin
            if (streaming_reg) begin
                plan.in_char = 1'b1;
            end else if (word_len_reg < w) begin
                store_we      = 1'b1;
                word_len_next = word_len_reg + LEN_W'(1);
            end else begin
                // Word outgrows the line: spill it and stream the rest
                plan.nl_first  = 1'b1;
                plan.word      = (word_len_reg != '0);
                plan.in_char   = 1'b1;
                streaming_next = 1'b1;
                err_next       = 1'b1;
            end
            last_nl_next = 1'b0;
            break_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_width_reg <= WIDTH_RESET;
            word_len_reg   <= '0;
            streaming_reg  <= 1'b0;
            line_used_reg  <= '0;
            break_reg      <= 1'b0;
            last_nl_reg    <= 1'b0;
            lfo_reg        <= 1'b0;
            err_reg        <= 1'b0;
            flushed_reg    <= 1'b0;
        end else begin
            if (cfg_write) begin
                line_width_reg <= cfg_data;
            end
            if (cmd.accept) begin
                word_len_reg  <= word_len_next;
                streaming_reg <= streaming_next;
                line_used_reg <= line_used_next;
                break_reg     <= break_next;
                last_nl_reg   <= last_nl_next;
                lfo_reg       <= lfo_next;
                err_reg       <= err_next;
                flushed_reg   <= flushed_next;
            end
        end
    end

    // Word read pointer; read address runs one step ahead of idx_reg
    always_comb
    begin
        if (cmd.accept) begin
            rd_addr = '0;
        end else if (cmd.idx_adv) begin
            rd_addr = idx_reg + IDX_W'(1);
        end else begin
            rd_addr = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept) begin
            emit_len_reg  <= word_len_reg;
            char_hold_reg <= in_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && store_we) begin
            word_store[word_len_reg[IDX_W-1:0]] <= in_byte;
        end
        rd_data_reg <= word_store[rd_addr];
    end

    // Output register
    always_comb
    begin
        case (cmd.sel)
            SEL_NL:    out_byte_mux = CH_NL;
            SEL_WORD:  out_byte_mux = rd_data_reg;
            SEL_CHAR:  out_byte_mux = char_hold_reg;
            SEL_SPACE: out_byte_mux = CH_SPACE;
            default:   out_byte_mux = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            out_byte_reg   <= out_byte_mux;
            byte_valid_reg <= (cmd.sel != SEL_NONE);
            last_reg       <= cmd.last;
            err_out_reg    <= err_reg;
        end
    end

    assign status.plan      = plan;
    assign status.word_last = ((idx_reg + IDX_W'(1)) == emit_len_reg[IDX_W-1:0]);
    assign status.can_load  = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_valid    = byte_valid_reg;
    assign last_of_run   = last_reg;
    assign too_long_seen = err_out_reg;

endmodule

// ===== sv/greedy_word_wrap.sv =====
// Top level of the greedy word wrap block.
// Depends on gww_pkg; instantiates gww_ctrl and gww_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one text byte per transfer,
//   or an end marker (end_of_text = 1) that flushes the last word, closes
//   the text with a newline (not after an oversize word), starts anew.
//   Output channel (out_valid / out_stall) carries the result transfers of
//   each item, one byte per transfer; last_of_run marks the final one. An
//   item that emits no text gives a single transfer with byte_valid = 0.
//   too_long_seen is the sticky oversize-word flag, as of the current item.
//   cfg_write / cfg_data set the line width (1..61, 0 acts as 1, above 61
//   acts as 61); write it only while the block is idle.
// Timing:
//   An item is taken when idle, then its results leave one per cycle
//   as long as the receiver does not stall. A word flush reads the word
//   store one byte a cycle, which sets the rate. in_stall stays high
//   while results are emitted.
// Reset: asynchronous, active low; line width returns to 40, text state and
//   the sticky flag clear. The word store needs no clearing.
// A stalled receiver holds the output register and freezes emission.
module greedy_word_wrap
    import gww_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [LEN_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       in_byte,
    input  logic             end_of_text,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             byte_valid,
    output logic             last_of_run,
    output logic             too_long_seen
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer: one emission stage at a time
    gww_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Text state, word store and output register
    gww_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .in_byte       (in_byte),
        .end_of_text   (end_of_text),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .last_of_run   (last_of_run),
        .too_long_seen (too_long_seen)
    );

endmodule
